/* src/pidc_pkg.sv */
// Shared types and constants for the dual-mode PID controller.
package pidc_pkg;

  // Width of every configuration register value apart from the mode bit.
  localparam int CFG_W   = 16;
  // Width of the configuration register index.
  localparam int CFG_IW  = 3;
  // Width of the drive word: the clamp limit is a 16-bit magnitude, so the
  // integer part of the output fits in 17 signed bits.
  localparam int DRIVE_W = CFG_W + 1;

  // Configuration register map.
  typedef enum logic [CFG_IW-1:0] {
    REG_MODE          = 3'd0,
    REG_MAX_OUTPUT    = 3'd1,
    REG_INTEGRAL_LIM  = 3'd2,
    REG_SEP_THRESHOLD = 3'd3,
    REG_GAIN_P        = 3'd4,
    REG_GAIN_I        = 3'd5,
    REG_GAIN_D        = 3'd6
  } cfg_reg_t;

  // Controller modes.
  typedef enum logic {
    MODE_POSITIONAL  = 1'b0,
    MODE_INCREMENTAL = 1'b1
  } pid_mode_t;

endpackage

/* src/pid_controller_dual_mode_unit.sv */
// Dual-mode (positional / incremental) PID controller with Q-format gains.
//
//  Channel | Direction | Handshake          | Word contents
//  --------+-----------+--------------------+-----------------------------------------
//  in      | input     | in_valid/in_ready  | measured, target, clear_history
//  out     | output    | out_valid/out_ready| drive, output_clamped, integral_separated
//  cfg     | input     | cfg_valid/cfg_ready| register index, write data
//
// One word is accepted per cycle with no gap unless a stall has filled both registers;
// each word passes from the input register into the output register and is offered there.
// The longest path is the 17x17 integral multiply, the integral add and clamp,
// the four-term sum and the output clamp.
// Synchronous reset (rst_n low) clears configuration and state and empties both
// registers. A stall holds both registers and drops in_ready once both are full.
module pid_controller_dual_mode_unit
  import pidc_pkg::*;
#(
  parameter int DATA_WIDTH     = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_measured,
  input  logic signed [DATA_WIDTH-1:0] in_target,
  input  logic                         in_clear_history,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DRIVE_W-1:0]    out_drive,
  output logic                         out_output_clamped,
  output logic                         out_integral_separated,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IW-1:0]            cfg_index,
  input  logic [CFG_W-1:0]             cfg_data
);

  // Error is one bit wider than the data.
  localparam int EW = DATA_WIDTH + 1;
  // Integral and incremental output keep the fraction bits; both are clamped
  // to a 16-bit integer magnitude, so they fit in this many signed bits.
  localparam int IW = CFG_W + GAIN_FRAC_BITS + 1;
  // Widest product: second difference (EW+2 bits) times a gain (CFG_W+1 signed).
  localparam int PW = EW + 2 + CFG_W + 1;
  localparam int LW = IW + 1;
  // Working width for sums: widest operand plus headroom for four terms.
  localparam int SW = ((PW > LW) ? PW : LW) + 3;
  // Width used to compare the error magnitude against the threshold.
  localparam int MW = ((EW + 1) > CFG_W) ? (EW + 1) : CFG_W;

  // Configuration registers.
  logic             mode_r;
  logic [CFG_W-1:0] max_output_r;
  logic [CFG_W-1:0] integral_limit_r;
  logic [CFG_W-1:0] sep_threshold_r;
  logic [CFG_W-1:0] gain_p_r;
  logic [CFG_W-1:0] gain_i_r;
  logic [CFG_W-1:0] gain_d_r;

  // Controller state.
  logic signed [EW-1:0] error_last_r;
  logic signed [EW-1:0] error_before_last_r;
  logic signed [IW-1:0] integral_accum_r;
  logic signed [IW-1:0] last_out_r;

  // Input register.
  logic                         s1_valid_r;
  logic signed [DATA_WIDTH-1:0] s1_measured_r;
  logic signed [DATA_WIDTH-1:0] s1_target_r;
  logic                         s1_clear_r;

  // Output register.
  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic                      out_clamped_r;
  logic                      out_sep_r;

  logic out_adv;
  logic s1_move;

  // Datapath signals.
  logic signed [EW-1:0]           err;
  logic signed [EW:0]             err_x;
  logic signed [EW:0]             mag;
  logic                           separate;
  logic signed [EW:0]             diff1;
  logic signed [EW+1:0]           diff2;
  logic signed [EW:0]             p_opnd;
  logic signed [EW+1:0]           d_opnd;
  logic signed [EW+CFG_W+1:0]     p_mul;
  logic signed [EW+CFG_W:0]       i_mul;
  logic signed [EW+CFG_W+2:0]     d_mul;
  logic signed [SW-1:0]           i_pre;
  logic signed [SW-1:0]           i_clamped;
  logic signed [SW-1:0]           base;
  logic signed [SW-1:0]           total;
  logic signed [SW-1:0]           result;
  logic                           hit;
  logic                           sep_flag;
  logic signed [DRIVE_W-1:0]      drive_nxt;

  // Symmetric clamp to +-(lim scaled by the gain fraction).
  function automatic logic signed [SW-1:0] clamp_sym(input logic signed [SW-1:0] v,
                                                     input logic [CFG_W-1:0] lim);
    logic signed [SW-1:0] l;
    l = $signed(SW'(lim)) <<< GAIN_FRAC_BITS;
    if (v > l) begin
      return l;
    end else if (v < -l) begin
      return -l;
    end else begin
      return v;
    end
  endfunction

  // The output register advances when empty or when its word is taken; the
  // input register moves its word forward whenever the output can advance.
  assign out_adv   = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_adv;
  assign in_ready  = !s1_valid_r || out_adv;
  assign cfg_ready = 1'b1;

  // Error and its history terms.
  assign err   = EW'(s1_target_r) - EW'(s1_measured_r);
  assign err_x = (EW + 1)'(err);
  assign mag   = err_x[EW] ? -err_x : err_x;
  assign separate = (sep_threshold_r != '0) &&
                    (MW'($unsigned(mag)) > MW'(sep_threshold_r));
  assign diff1 = (EW + 1)'(err) - (EW + 1)'(error_last_r);
  assign diff2 = (EW + 2)'(err) - ((EW + 2)'(error_last_r) <<< 1)
                 + (EW + 2)'(error_before_last_r);

  // Positional mode uses the error for P and its first difference for D;
  // incremental mode uses the first and second differences.
  assign p_opnd = (mode_r == MODE_INCREMENTAL) ? diff1 : err_x;
  assign d_opnd = (mode_r == MODE_INCREMENTAL) ? diff2 : (EW + 2)'(diff1);

  // The three gain multiplies run side by side.
  assign p_mul = $signed({1'b0, gain_p_r}) * p_opnd;
  assign i_mul = $signed({1'b0, gain_i_r}) * err;
  assign d_mul = $signed({1'b0, gain_d_r}) * d_opnd;

  always_comb begin
    // Integral term: accumulated (or separated) in positional mode, the bare
    // I increment in incremental mode; clamped in both.
    if (mode_r == MODE_INCREMENTAL) begin
      i_pre = SW'(i_mul);
    end else if (separate) begin
      i_pre = '0;
    end else begin
      i_pre = SW'(integral_accum_r) + SW'(i_mul);
    end
    i_clamped = clamp_sym(i_pre, integral_limit_r);

    base   = (mode_r == MODE_INCREMENTAL) ? SW'(last_out_r) : '0;
    total  = base + SW'(p_mul) + i_clamped + SW'(d_mul);
    result = clamp_sym(total, max_output_r);
    hit    = (result != total);
    sep_flag = (mode_r == MODE_POSITIONAL) && separate;
    // Dropping the fraction by arithmetic shift rounds toward negative infinity.
    drive_nxt = DRIVE_W'(result >>> GAIN_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r              <= MODE_POSITIONAL;
      max_output_r        <= '0;
      integral_limit_r    <= '0;
      sep_threshold_r     <= '0;
      gain_p_r            <= '0;
      gain_i_r            <= '0;
      gain_d_r            <= '0;
      error_last_r        <= '0;
      error_before_last_r <= '0;
      integral_accum_r    <= '0;
      last_out_r          <= '0;
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MODE:          mode_r           <= cfg_data[0];
          REG_MAX_OUTPUT:    max_output_r     <= cfg_data;
          REG_INTEGRAL_LIM:  integral_limit_r <= cfg_data;
          REG_SEP_THRESHOLD: sep_threshold_r  <= cfg_data;
          REG_GAIN_P:        gain_p_r         <= cfg_data;
          REG_GAIN_I:        gain_i_r         <= cfg_data;
          REG_GAIN_D:        gain_d_r         <= cfg_data;
          default: begin
          end
        endcase
      end

      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end

      // The controller state advances exactly when a word leaves the input
      // register, so back-to-back words see the state left by the previous one.
      if (s1_move) begin
        if (s1_clear_r) begin
          error_last_r        <= '0;
          error_before_last_r <= '0;
          last_out_r          <= '0;
        end else begin
          error_before_last_r <= error_last_r;
          error_last_r        <= err;
          integral_accum_r    <= IW'(i_clamped);
          if (mode_r == MODE_INCREMENTAL) begin
            last_out_r <= IW'(result);
          end
        end
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_measured_r <= in_measured;
      s1_target_r   <= in_target;
      s1_clear_r    <= in_clear_history;
    end
    if (s1_move) begin
      if (s1_clear_r) begin
        out_drive_r   <= '0;
        out_clamped_r <= 1'b0;
        out_sep_r     <= 1'b0;
      end else begin
        out_drive_r   <= drive_nxt;
        out_clamped_r <= hit;
        out_sep_r     <= sep_flag;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_drive              = out_drive_r;
  assign out_output_clamped     = out_clamped_r;
  assign out_integral_separated = out_sep_r;

endmodule

/* dv/pid_controller_dual_mode_unit_test.sv */
// Self-checking testbench for the dual-mode PID controller, with a built-in predictor.
module pid_controller_dual_mode_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pidc_pkg::*;

  localparam int DW   = 16;
  localparam int FRAC = 8;

  // One result word as the predictor sees it.
  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
    logic                      separated;
  } drive_word_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [DW-1:0]      in_measured = '0;
  logic signed [DW-1:0]      in_target = '0;
  logic                      in_clear_history = 1'b0;
  logic                      out_valid;
  logic                      out_ready = 1'b1;
  logic signed [DRIVE_W-1:0] out_drive;
  logic                      out_output_clamped;
  logic                      out_integral_separated;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IW-1:0]         cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;

  // Predictor copy of the configuration registers.
  pid_mode_t    ctl_mode = MODE_POSITIONAL;
  logic [15:0]  max_out = '0;
  logic [15:0]  int_lim = '0;
  logic [15:0]  sep_thr = '0;
  logic [15:0]  kp = '0;
  logic [15:0]  ki = '0;
  logic [15:0]  kd = '0;

  // Predictor copy of the controller state.
  logic signed [16:0] err_last = '0;
  logic signed [16:0] err_before = '0;
  logic signed [25:0] integ = '0;
  logic signed [25:0] incr_out = '0;

  // Expected result words, oldest first.
  drive_word_t pending_drive[$];

  int          fail_count = 0;
  // Idling controls: the sender inserts gaps, the receiver stalls in bursts.
  bit          in_gaps = 1'b0;
  bit          out_stalls = 1'b0;
  int          stall_left = 0;
  // Setpoint that the random stimulus holds for a while, so the integral and
  // the error history see realistic tracking sequences.
  int          setpoint = 0;

  pid_controller_dual_mode_unit uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_measured            (in_measured),
    .in_target              (in_target),
    .in_clear_history       (in_clear_history),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_drive              (out_drive),
    .out_output_clamped     (out_output_clamped),
    .out_integral_separated (out_integral_separated),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Symmetric clamp of a value with FRAC fraction bits against an integer
  // magnitude. The clamp only applies when the magnitude strictly exceeds it.
  function automatic longint clamp_mag(input longint v, input logic [15:0] lim,
                                       output logic hit);
    longint bound;
    bound = longint'(lim) <<< FRAC;
    hit = 1'b0;
    if (v > bound) begin
      v = bound;
      hit = 1'b1;
    end
    if (v < -bound) begin
      v = -bound;
      hit = 1'b1;
    end
    return v;
  endfunction

  // Advances the predicted controller by one accepted sample and returns
  // the result word it must produce.
  function automatic drive_word_t pid_tick(input logic signed [DW-1:0] meas,
                                           input logic signed [DW-1:0] targ,
                                           input logic clr);
    drive_word_t w;
    longint      err, mag, e1, e2, p, i, d, sum;
    logic        hit, ihit, sep_now;
    w = '{default: '0};
    // A clear wipes the error history and the stored incremental output but
    // keeps the integral; the result word is all zero.
    if (clr) begin
      err_last = '0;
      err_before = '0;
      incr_out = '0;
      return w;
    end
    err = longint'(targ) - longint'(meas);
    mag = (err < 0) ? -err : err;
    sep_now = (sep_thr != 0) && (mag > longint'(sep_thr));
    e1 = longint'(err_last);
    e2 = longint'(err_before);
    if (ctl_mode == MODE_POSITIONAL) begin
      p = longint'(kp) * err;
      i = longint'(integ) + longint'(ki) * err;
      // Separation zeroes the integral before it is clamped.
      if (sep_now) i = 0;
      i = clamp_mag(i, int_lim, ihit);
      integ = i[25:0];
      d = longint'(kd) * (err - e1);
      sum = clamp_mag(p + i + d, max_out, hit);
      w.separated = sep_now;
    end else begin
      // The clamped I increment overwrites the shared integral register.
      p = longint'(kp) * (err - e1);
      i = clamp_mag(longint'(ki) * err, int_lim, ihit);
      integ = i[25:0];
      d = longint'(kd) * (err - 2 * e1 + e2);
      sum = clamp_mag(longint'(incr_out) + p + i + d, max_out, hit);
      incr_out = sum[25:0];
    end
    err_before = err_last;
    err_last = err[16:0];
    // Dropping the fraction with an arithmetic shift rounds toward minus infinity.
    sum = sum >>> FRAC;
    w.drive = sum[DRIVE_W-1:0];
    w.clamped = hit;
    return w;
  endfunction

  // Receiver side: out_ready drops in bursts, each lasting until stall_left has counted
  // down, while stalls are enabled. A burst that has started always runs to its end.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (out_stalls && $urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_ready = 1'b1;
    end
  end

  // Result checker: every accepted result word is matched against the oldest
  // expected word. Only the first ten failures are printed.
  always @(posedge clk) begin
    drive_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_drive.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: result word with nothing expected: drive=%0d clamped=%0b sep=%0b",
                   $realtime, out_drive, out_output_clamped, out_integral_separated);
      end else begin
        want = pending_drive.pop_front();
        if (want.drive !== out_drive || want.clamped !== out_output_clamped ||
            want.separated !== out_integral_separated) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: want drive=%0d clamped=%0b sep=%0b, got drive=%0d clamped=%0b sep=%0b",
                     $realtime, want.drive, want.clamped, want.separated,
                     out_drive, out_output_clamped, out_integral_separated);
        end
      end
    end
  end

  // Sends one sample word, with an optional random gap in front of it, and
  // records the result it must cause once the word is accepted.
  task automatic send_sample(input logic signed [DW-1:0] meas,
                             input logic signed [DW-1:0] targ, input logic clr);
    int gap;
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_measured = meas;
    in_target = targ;
    in_clear_history = clr;
    do @(posedge clk); while (!in_ready);
    pending_drive.push_back(pid_tick(meas, targ, clr));
  endtask

  // Holds the sender off until every expected word has arrived, then lets the
  // two-stage pipeline settle before anything else happens.
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MODE:          ctl_mode = pid_mode_t'(val[0]);
      REG_MAX_OUTPUT:    max_out = val;
      REG_INTEGRAL_LIM:  int_lim = val;
      REG_SEP_THRESHOLD: sep_thr = val;
      REG_GAIN_P:        kp = val;
      REG_GAIN_I:        ki = val;
      REG_GAIN_D:        kd = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Reprograms every register once the controller has gone quiet.
  task automatic program_controller(input pid_mode_t m, input logic [15:0] maxo,
                                    input logic [15:0] ilim, input logic [15:0] sep,
                                    input logic [15:0] gp, input logic [15:0] gi,
                                    input logic [15:0] gd);
    wait_for_idle();
    write_reg(REG_MODE, {15'd0, m});
    write_reg(REG_MAX_OUTPUT, maxo);
    write_reg(REG_INTEGRAL_LIM, ilim);
    write_reg(REG_SEP_THRESHOLD, sep);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
  endtask

  // Gains: mostly moderate so the output is not pinned at the clamp, with
  // the zero and all-ones extremes mixed in.
  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'h0400));
    endcase
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'h4000));
    endcase
  endfunction

  // Random samples: mostly a measured value tracking a setpoint that moves
  // now and then, with some full-range noise and occasional clears.
  task automatic send_random_samples(input int count);
    int                   meas_v;
    logic signed [DW-1:0] t, m;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 7) == 0) begin
        t = 16'($urandom());
        m = 16'($urandom());
      end else begin
        if ($urandom_range(0, 19) == 0)
          setpoint = int'($urandom_range(0, 4000)) - 2000;
        meas_v = setpoint + int'($urandom_range(0, 1000)) - 500;
        t = setpoint[15:0];
        m = meas_v[15:0];
      end
      send_sample(m, t, $urandom_range(0, 24) == 0);
    end
  endtask

  // Straight out of reset every gain and limit is zero, so even the
  // largest errors must drive zero with no flags.
  task automatic test_reset_state();
    send_sample(16'sh7FFF, -16'sh8000, 1'b0);
    send_sample(-16'sh8000, 16'sh7FFF, 1'b0);
    wait_for_idle();
  endtask

  // Positional mode with unit P gain: integral build-up, the separation
  // threshold right at and just past its value, the largest errors of
  // either sign, and a clear in the middle of a run.
  task automatic test_positional_path();
    program_controller(MODE_POSITIONAL, 16'd1000, 16'd500, 16'd200,
                       16'h0100, 16'h0080, 16'h0040);
    send_sample(16'sd0, 16'sd50, 1'b0);
    send_sample(16'sd0, 16'sd100, 1'b0);
    send_sample(16'sd0, 16'sd200, 1'b0);
    send_sample(16'sd0, 16'sd201, 1'b0);
    send_sample(-16'sh8000, 16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, -16'sh8000, 1'b0);
    send_sample(16'sd10, 16'sd0, 1'b1);
    send_sample(16'sd0, -16'sd5, 1'b0);
    wait_for_idle();
  endtask

  // Incremental mode with every gain and limit at its maximum, so the
  // output saturates at both ends; the clear also resets the stored output.
  task automatic test_incremental_path();
    program_controller(MODE_INCREMENTAL, 16'hFFFF, 16'hFFFF, 16'd1,
                       16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(-16'sh8000, 16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, -16'sh8000, 1'b0);
    send_sample(16'sd0, 16'sd1, 1'b0);
    send_sample(16'sd3, 16'sd3, 1'b1);
    send_sample(16'sd5, 16'sd7, 1'b0);
    wait_for_idle();
  endtask

  // Zero limits: any nonzero sum is clamped to zero and flagged, in both modes.
  task automatic test_zero_limits();
    program_controller(MODE_POSITIONAL, 16'd0, 16'd0, 16'd0,
                       16'h0100, 16'h0100, 16'h0100);
    send_sample(16'sd0, 16'sd3, 1'b0);
    send_sample(16'sd0, -16'sd3, 1'b0);
    program_controller(MODE_INCREMENTAL, 16'd0, 16'd0, 16'd0,
                       16'h0100, 16'h0100, 16'h0100);
    send_sample(16'sd0, 16'sd3, 1'b0);
    send_sample(16'sd4, 16'sd0, 1'b0);
    wait_for_idle();
  endtask

  // Several random tunings, each with idling on either side switched on at random; each phase drains
  // completely before the registers are rewritten.
  task automatic test_random_tuning();
    logic [15:0] sep;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 5))
        0, 1, 2: sep = 16'd0;
        3:       sep = 16'hFFFF;
        default: sep = 16'($urandom_range(1, 2000));
      endcase
      program_controller(pid_mode_t'($urandom_range(0, 1)), pick_limit(), pick_limit(),
                         sep, pick_gain(), pick_gain(), pick_gain());
      in_gaps = ($urandom_range(0, 3) != 0);
      out_stalls = ($urandom_range(0, 3) != 0);
      send_random_samples(150);
    end
  endtask

  // Closing stretch at full rate with no idling on either side. Idling is
  // switched off before the drain so that no stall burst reaches the stream.
  task automatic test_steady_stream();
    in_gaps = 1'b0;
    out_stalls = 1'b0;
    program_controller(pid_mode_t'($urandom_range(0, 1)), 16'($urandom_range(100, 16'h4000)),
                       16'($urandom_range(100, 16'h4000)), 16'($urandom_range(0, 3000)),
                       16'($urandom_range(0, 16'h0300)), 16'($urandom_range(0, 16'h0100)),
                       16'($urandom_range(0, 16'h0200)));
    send_random_samples(200);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_positional_path();
    test_incremental_path();
    test_zero_limits();
    test_random_tuning();
    test_steady_stream();
    wait_for_idle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("pid_controller_dual_mode_unit test passed");
    end else begin
      $display("pid_controller_dual_mode_unit test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run with maximal idling.
  initial begin
    #10_000_000;
    $display("pid_controller_dual_mode_unit test failed");
    $finish;
  end

endmodule

/* pid_controller_dual_mode_unit.f */
src/pidc_pkg.sv
src/pid_controller_dual_mode_unit.sv
dv/pid_controller_dual_mode_unit_test.sv
